>>> hw/rtl/bgd_pkg.sv
// Package for the button gesture decoder: event codes, hold marks,
// register indexes and the result entry type. No dependencies.
package bgd_pkg;

	typedef enum logic [2:0] {
		EV_HOLD         = 3'd0,
		EV_HOLD_RELEASE = 3'd1,
		EV_CLICKS       = 3'd2,
		EV_SPECIAL      = 3'd3,
		EV_RESET        = 3'd4
	} ev_t;

	typedef enum logic [1:0] {
		HM_NONE  = 2'd0,
		HM_HELD  = 2'd1,
		HM_FIXED = 2'd2
	} hm_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE_LIMIT = 2'd0,
		REG_CLICK_WINDOW   = 2'd1,
		REG_RESET_CLICKS   = 2'd2,
		REG_SPECIAL_CLICKS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] clicks;
		ev_t        event_res;
		logic [2:0] which_button;
		logic       last;
	} res_t;

	localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd16;
	localparam logic [31:0] CLICK_WINDOW_RST   = 32'd8000000;
	localparam logic [7:0]  RESET_CLICKS_RST   = 8'd5;
	localparam logic [7:0]  SPECIAL_CLICKS_RST = 8'd4;
	localparam logic [7:0]  DEBOUNCE_SETTLED   = 8'd1;
	localparam logic [7:0]  CLICK_SAT          = 8'd255;

endpackage

>>> hw/rtl/button_gesture_decoder_unit.sv
// Top level of the button gesture decoder: poll input register, per-button
// state, single-pass gesture logic and a four-entry result queue.
// Depends on bgd_pkg.
//
// Usage: each transfer on the s_axis channel is one poll of one button
// (tdata: button, pin_low, now). Each m_axis transfer is one gesture event
// (tdata: which_button, event_res, clicks; tlast marks the final event of a
// poll). A poll gives zero, one or two events. The cfg channel writes the
// four registers and is always ready; write only while the block is idle.
// A poll is held in the input register until the queue has room; its
// events are then written into the result queue, from which the first
// event is presented on m_axis. One poll is taken every cycle while the
// queue holds two entries or fewer; the queue drains one event a cycle
// while the receiver is ready, so the output port sets the sustained rate
// when polls give events. When the receiver stalls, the queue fills and
// s_axis_tready falls once fewer than two entries are free.
// Reset clears the registers to their default values, every button to
// released and settled, and empties the queue.
module button_gesture_decoder_unit #(
	parameter int BUTTONS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // button[2:0], pin_low[3], now[35:4], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // which_button[2:0], event_res[5:3], clicks[7:6]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bgd_pkg::*;

	localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	logic [7:0]  debounce_limit_q;
	logic [31:0] click_window_q;
	logic [7:0]  reset_clicks_q;
	logic [7:0]  special_clicks_q;

	logic [7:0]  dcnt_q  [BUTTONS];
	logic        prs_q   [BUTTONS];
	logic        rel_q   [BUTTONS];
	hm_t         hm_q    [BUTTONS];
	logic [7:0]  cc_q    [BUTTONS];
	logic [31:0] stamp_q [BUTTONS];

	logic        valid_s1;
	logic [2:0]  button_s1;
	logic        pin_s1;
	logic [31:0] now_s1;

	res_t        fifo_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  cnt_q;

	logic        room;
	logic        adv;
	logic        pop;
	logic [4:0]  btn_ext;
	logic [IW-1:0] idx;
	logic        in_range;
	logic        wr_state;

	logic [7:0]  dcnt;
	logic        prs;
	logic        rel;
	hm_t         hm;
	logic [7:0]  cc;
	logic [31:0] stamp;
	logic [31:0] elapsed;
	logic        wp0;
	logic        wp1;
	logic        hold_ev;
	logic        close;
	logic        close_ev;
	ev_t         close_code;
	logic [1:0]  close_clicks;

	logic [7:0]  dcnt_n;
	logic        prs_n;
	logic        rel_n;
	hm_t         hm_n;
	logic [7:0]  cc_n;
	logic [31:0] stamp_n;
	logic        stamp_upd;

	res_t        res0;
	res_t        res1;
	logic [1:0]  n_res;

	assign cfg_ready     = 1'b1;
	assign room          = (cnt_q <= 3'd2);
	assign adv           = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = {fifo_q[rd_ptr_q].clicks, fifo_q[rd_ptr_q].event_res,
		fifo_q[rd_ptr_q].which_button};
	assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

	assign btn_ext  = {2'b00, button_s1};
	assign idx      = btn_ext[IW-1:0];
	assign in_range = (btn_ext < 5'(BUTTONS));
	assign wr_state = adv && in_range;

	always_comb begin
		dcnt         = dcnt_q[idx];
		prs          = prs_q[idx];
		rel          = rel_q[idx];
		hm           = hm_q[idx];
		cc           = cc_q[idx];
		stamp        = stamp_q[idx];
		elapsed      = now_s1 - stamp;
		wp0          = (elapsed > click_window_q);
		dcnt_n       = dcnt;
		prs_n        = prs;
		rel_n        = rel;
		hm_n         = hm;
		cc_n         = cc;
		stamp_n      = stamp;
		stamp_upd    = 1'b0;
		hold_ev      = 1'b0;
		close_ev     = 1'b0;
		close_code   = EV_HOLD;
		close_clicks = 2'd0;

		if (pin_s1) begin
			if (prs && wp0 && (hm == HM_NONE)) begin
				hold_ev = 1'b1;
				hm_n    = HM_HELD;
			end
			if (dcnt != debounce_limit_q) begin
				dcnt_n = dcnt + 8'd1;
				if (dcnt_n == debounce_limit_q) begin
					prs_n     = 1'b1;
					stamp_n   = now_s1;
					stamp_upd = 1'b1;
					if (!wp0) begin
						if (cc != CLICK_SAT) begin
							cc_n = cc + 8'd1;
						end
					end else begin
						cc_n = 8'd1;
					end
				end
			end
		end else begin
			if (dcnt != DEBOUNCE_SETTLED) begin
				dcnt_n = dcnt - 8'd1;
				if ((dcnt_n == DEBOUNCE_SETTLED) && (prs || (hm == HM_FIXED))) begin
					rel_n = 1'b1;
				end
			end
		end

		// A fresh stamp equals now, so no time has passed since it.
		wp1   = wp0 && !stamp_upd;
		close = rel_n && wp1;

		if (close) begin
			priority if (cc_n >= reset_clicks_q) begin
				close_ev   = 1'b1;
				close_code = EV_RESET;
			end else if (hm_n != HM_NONE) begin
				close_ev   = 1'b1;
				close_code = EV_HOLD_RELEASE;
			end else if ((cc_n >= 8'd1) && (cc_n <= 8'd3)) begin
				close_ev     = 1'b1;
				close_code   = EV_CLICKS;
				close_clicks = cc_n[1:0];
			end else if (cc_n == special_clicks_q) begin
				close_ev   = 1'b1;
				close_code = EV_SPECIAL;
			end else begin
				close_ev = 1'b0;
			end
			cc_n  = 8'd0;
			prs_n = 1'b0;
			rel_n = 1'b0;
			hm_n  = HM_NONE;
		end else if (prs_n && (cc_n == 8'd1) && (hm_n == HM_HELD)) begin
			hm_n  = HM_FIXED;
			cc_n  = 8'd0;
			prs_n = 1'b0;
		end

		res1.which_button = button_s1;
		res1.event_res    = close_code;
		res1.clicks       = close_clicks;
		res1.last         = 1'b1;
		if (hold_ev) begin
			res0.which_button = button_s1;
			res0.event_res    = EV_HOLD;
			res0.clicks       = 2'd0;
			res0.last         = !close_ev;
		end else begin
			res0 = res1;
		end
		if (!in_range) begin
			n_res = 2'd0;
		end else begin
			n_res = {1'b0, hold_ev} + {1'b0, close_ev};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= DEBOUNCE_LIMIT_RST;
			click_window_q   <= CLICK_WINDOW_RST;
			reset_clicks_q   <= RESET_CLICKS_RST;
			special_clicks_q <= SPECIAL_CLICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_data[7:0];
				REG_CLICK_WINDOW:   click_window_q   <= cfg_data;
				REG_RESET_CLICKS:   reset_clicks_q   <= cfg_data[7:0];
				REG_SPECIAL_CLICKS: special_clicks_q <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUTTONS; b++) begin
				dcnt_q[b]  <= DEBOUNCE_SETTLED;
				prs_q[b]   <= 1'b0;
				rel_q[b]   <= 1'b0;
				hm_q[b]    <= HM_NONE;
				cc_q[b]    <= 8'd0;
				stamp_q[b] <= 32'd0;
			end
		end else if (wr_state) begin
			dcnt_q[idx]  <= dcnt_n;
			prs_q[idx]   <= prs_n;
			rel_q[idx]   <= rel_n;
			hm_q[idx]    <= hm_n;
			cc_q[idx]    <= cc_n;
			stamp_q[idx] <= stamp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			button_s1 <= s_axis_tdata[2:0];
			pin_s1    <= s_axis_tdata[3];
			now_s1    <= s_axis_tdata[35:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (adv ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (n_res != 2'd0)) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (adv && (n_res == 2'd2)) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

endmodule

>>> hw/rtl/bgd_checker.sv
// Port-level checker for the button gesture decoder, bound to the top level.
// Depends on bgd_pkg and button_gesture_decoder_unit.
module bgd_checker #(
	parameter int BUTTONS = 6
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);
	import bgd_pkg::*;

	// A stalled transfer keeps its event and its last flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// Only a clicks event carries a click count.
	a_clicks_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:6] == 2'd0) ||
		(m_axis_tdata[5:3] == EV_CLICKS))
		else $error("click count on a non-click event");

	// A hold is never the only event of a poll that also closes, and a
	// non-final result can only be a hold.
	a_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[5:3] == EV_HOLD))
		else $error("non-final result is not a hold");

	// Results name only existing buttons.
	a_button_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ({2'b00, m_axis_tdata[2:0]} < 5'(BUTTONS)))
		else $error("result for a button out of range");

endmodule

bind button_gesture_decoder_unit bgd_checker #(.BUTTONS(BUTTONS)) u_bgd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
